### rtl/slxpp_pkg.sv
// ----------------------------------------------------------------------------
// slxpp_pkg
// Shared types and codes for the start/type/length/payload/XOR deframer.
// ----------------------------------------------------------------------------
package slxpp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADLEN  = 2'd2,
    ST_BADCSUM = 2'd3
  } status_t;

  // Front-end parse phase
  typedef enum logic [2:0] {
    PH_SOF1 = 3'd0,
    PH_SOF2 = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  // Back-end sequencer state
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } back_state_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_FIRST  = 2'd0,
    REG_START_SECOND = 2'd1,
    REG_MAX_PAYLOAD  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [6:0] max_payload;
  } cfg_t;

  // One verdict handed from the front end to the back end
  typedef struct packed {
    status_t    status;
    logic [7:0] ptype;
    logic [7:0] plen;
  } cmd_t;

  localparam logic [7:0] START_FIRST_RST  = 8'd170;
  localparam logic [7:0] START_SECOND_RST = 8'd85;
  localparam logic [6:0] MAX_PAYLOAD_RST  = 7'd64;

endpackage

### rtl/slxpp_in_if.sv
// ----------------------------------------------------------------------------
// slxpp_in_if
// Received-byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface slxpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/slxpp_out_if.sv
// ----------------------------------------------------------------------------
// slxpp_out_if
// Result channel: valid/ready handshake with one parsed result.
// ----------------------------------------------------------------------------
interface slxpp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] packet_type;
  logic [7:0] payload_length;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last;

  modport source (output valid, output status, output packet_type,
                  output payload_length, output data_byte, output byte_index,
                  output last, input ready);
  modport sink   (input valid, input status, input packet_type,
                  input payload_length, input data_byte, input byte_index,
                  input last, output ready);
endinterface

### rtl/slxpp_front.sv
// ----------------------------------------------------------------------------
// slxpp_front
// Byte parser: hunts start bytes, checks length and XOR, writes payload
// bytes to the buffer and posts one verdict per packet to the queue.
// ----------------------------------------------------------------------------
module slxpp_front #(
  parameter int PAYLOAD_DEPTH = 64,
  parameter int AW            = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slxpp_pkg::cfg_t   cfg,
  slxpp_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output slxpp_pkg::cmd_t   q_cmd,
  input  logic              run_done,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data
);
  import slxpp_pkg::*;

  localparam logic [6:0] DEPTH_W = 7'(PAYLOAD_DEPTH);

  phase_t     phase_r, phase_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       busy_r, busy_nxt;

  logic [6:0] limit;
  logic       body_write;
  logic       accept;
  logic [7:0] b;

  assign b          = in_ch.rx_byte;
  assign limit      = (cfg.max_payload > DEPTH_W) ? DEPTH_W : cfg.max_payload;
  assign body_write = (phase_r == PH_BODY) && (cnt_r < len_r);
  // hold payload bytes while the buffer still drains the previous run
  assign in_ch.ready = !q_full && !(body_write && busy_r);
  assign accept      = in_ch.valid && in_ch.ready;

  assign wr_en   = accept && body_write;
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOF1;
      cnt_r   <= '0;
      len_r   <= '0;
      type_r  <= '0;
      xor_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      xor_r   <= xor_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    xor_nxt   = xor_r;
    busy_nxt  = busy_r && !run_done;
    q_push    = 1'b0;
    q_cmd     = '{status: ST_BADLEN, ptype: type_r, plen: {1'b0, len_r}};
    if (accept) begin
      unique case (phase_r)
        PH_SOF1: begin
          if (b == cfg.start_first) phase_nxt = PH_SOF2;
        end
        PH_SOF2: begin
          if (b == cfg.start_second) begin
            phase_nxt = PH_TYPE;
          end else if (b != cfg.start_first) begin
            phase_nxt = PH_SOF1;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end
        end
        PH_TYPE: begin
          type_nxt  = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (b > {1'b0, limit}) begin
            q_push    = 1'b1;
            q_cmd     = '{status: ST_BADLEN, ptype: type_r, plen: b};
            phase_nxt = PH_SOF1;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end else begin
            len_nxt   = b[6:0];
            cnt_nxt   = '0;
            xor_nxt   = type_r ^ b;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_write) begin
            xor_nxt = xor_r ^ b;
            cnt_nxt = cnt_r + 7'd1;
          end else begin
            q_push = 1'b1;
            if (b != xor_r) begin
              q_cmd.status = ST_BADCSUM;
            end else if (len_r == '0) begin
              q_cmd.status = ST_EMPTY;
            end else begin
              q_cmd.status = ST_DATA;
              busy_nxt     = 1'b1;
            end
            phase_nxt = PH_SOF1;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_SOF1;
          cnt_nxt   = '0;
          len_nxt   = '0;
        end
      endcase
    end
  end

endmodule

### rtl/slxpp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// slxpp_cmd_fifo
// Two-entry verdict queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module slxpp_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  slxpp_pkg::cmd_t push_cmd,
  input  logic            pop,
  output slxpp_pkg::cmd_t head_cmd,
  output logic            full,
  output logic            empty
);
  import slxpp_pkg::*;

  cmd_t       entry_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wptr_r] <= push_cmd;
  end

endmodule

### rtl/slxpp_back.sv
// ----------------------------------------------------------------------------
// slxpp_back
// Result sequencer: owns the payload buffer, turns each verdict into one
// error/empty result or a run of payload-byte results.
// ----------------------------------------------------------------------------
module slxpp_back #(
  parameter int PAYLOAD_DEPTH = 64,
  parameter int AW            = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  slxpp_pkg::cmd_t q_head,
  output logic            q_pop,
  output logic            run_done,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  slxpp_out_if.source     out_ch
);
  import slxpp_pkg::*;

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] mem_q;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic        is_last;
  logic        send_ok;

  assign is_last = (cmd_r.status != ST_DATA) ||
                   ((8'(idx_r) + 8'd1) == cmd_r.plen);
  assign send_ok = (state_r == BK_SEND) && out_ch.ready;

  assign out_ch.valid          = (state_r == BK_SEND);
  assign out_ch.status         = cmd_r.status;
  assign out_ch.packet_type    = cmd_r.ptype;
  assign out_ch.payload_length = cmd_r.plen;
  assign out_ch.data_byte      = (cmd_r.status == ST_DATA) ? mem_q : 8'd0;
  assign out_ch.byte_index     = 6'(idx_r);
  assign out_ch.last           = is_last;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_r == BK_READ) mem_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    run_done  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          idx_nxt   = '0;
          state_nxt = (q_head.status == ST_DATA) ? BK_READ : BK_SEND;
        end
      end
      BK_READ: begin
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (send_ok) begin
          if (is_last) begin
            // release the buffer to the parser once the run is out
            run_done  = (cmd_r.status == ST_DATA);
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = BK_READ;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

endmodule

### rtl/sof_length_xor_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// sof_length_xor_packet_parser_unit
// Start-of-frame / type / length / payload / XOR-check deframer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per transaction; out_ch carries results
//   (payload byte, empty packet, bad length, bad checksum). cfg_we writes
//   register cfg_index with cfg_wdata; write only while idle.
// Throughput:
//   The parser takes one byte per cycle; in_ch.ready drops while the
//   two-entry verdict queue is full, and on a payload byte while the buffer
//   still drains the previous good packet's run. The sequencer pops a verdict,
//   then for each payload byte reads the buffer and then outputs the byte;
//   any other result is output directly after the pop.
// Result path:
//   With an idle sequencer, a verdict is registered in the queue, then
//   popped; a payload run reads the buffer before its first result shows.
// Reset:
//   rst_n (synchronous) resets state and config registers, returns the
//   parser to hunting and empties the queue. The payload buffer is not
//   cleared; every entry read was written earlier in the same packet.
// Stall:
//   A low out_ch.ready holds the current result; the queue and parser keep
//   going until the queue fills or a payload byte meets a busy buffer.
// ----------------------------------------------------------------------------
module sof_length_xor_packet_parser_unit #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  slxpp_in_if.sink   in_ch,
  slxpp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import slxpp_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  cfg_t cfg_r, cfg_nxt;

  logic          q_push, q_pop, q_full, q_empty;
  cmd_t          q_cmd, q_head;
  logic          run_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_FIRST:  cfg_nxt.start_first  = cfg_wdata;
        REG_START_SECOND: cfg_nxt.start_second = cfg_wdata;
        REG_MAX_PAYLOAD:  cfg_nxt.max_payload  = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_first:  START_FIRST_RST,
                 start_second: START_SECOND_RST,
                 max_payload:  MAX_PAYLOAD_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  slxpp_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .AW           (AW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .run_done(run_done),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  slxpp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head_cmd(q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  slxpp_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .AW           (AW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .run_done(run_done),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .out_ch  (out_ch)
  );

endmodule

### tb/slxpp_parse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slxpp_parse_checker
// Watches the byte and result channels of the deframer, tracks the frame
// parse and the register writes, and checks every result in order.
// ----------------------------------------------------------------------------
module slxpp_parse_checker (
  input  logic        clk,
  input  logic        rst_n,
  slxpp_in_if         in_mon,
  slxpp_out_if        out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int unsigned pending_results,
  output int unsigned fail_count
);
  import slxpp_pkg::*;

  localparam int BUF_DEPTH = 64;

  typedef struct packed {
    status_t    status;
    logic [7:0] ptype;
    logic [7:0] plen;
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } parse_result_t;

  parse_result_t result_q[$];

  logic [7:0] start_first;
  logic [7:0] start_second;
  logic [6:0] max_payload;

  phase_t     phase;
  logic [6:0] byte_cnt;
  logic [6:0] body_len;
  logic [7:0] hdr_type;
  logic [7:0] csum_acc;
  logic [7:0] body_buf [BUF_DEPTH];

  int unsigned mismatches;

  function automatic string result_str(parse_result_t r);
    return $sformatf("status=%0d type=%02h len=%02h data=%02h idx=%0d last=%0b",
                     r.status, r.ptype, r.plen, r.data, r.idx, r.last);
  endfunction

  task automatic restart_hunt();
    phase    = PH_SOF1;
    byte_cnt = '0;
    body_len = '0;
  endtask

  task automatic push_verdict(input status_t st, input logic [7:0] plen);
    result_q.push_back('{status: st, ptype: hdr_type, plen: plen, data: 8'h00,
                         idx: 6'd0, last: 1'b1});
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [6:0] lim;
    lim = (max_payload > 7'd64) ? 7'd64 : max_payload;
    case (phase)
      PH_SOF1: begin
        if (b == start_first) phase = PH_SOF2;
      end
      PH_SOF2: begin
        // second start byte wins when both codes are equal
        if (b == start_second) phase = PH_TYPE;
        else if (b != start_first) restart_hunt();
      end
      PH_TYPE: begin
        hdr_type = b;
        phase    = PH_LEN;
      end
      PH_LEN: begin
        if (b > {1'b0, lim}) begin
          push_verdict(ST_BADLEN, b);
          restart_hunt();
        end else begin
          body_len = b[6:0];
          byte_cnt = '0;
          csum_acc = hdr_type ^ b;
          phase    = PH_BODY;
        end
      end
      PH_BODY: begin
        if (byte_cnt < body_len) begin
          body_buf[byte_cnt[5:0]] = b;
          csum_acc = csum_acc ^ b;
          byte_cnt = byte_cnt + 7'd1;
        end else if (b != csum_acc) begin
          push_verdict(ST_BADCSUM, {1'b0, body_len});
          restart_hunt();
        end else if (body_len == 7'd0) begin
          push_verdict(ST_EMPTY, 8'h00);
          restart_hunt();
        end else begin
          for (int i = 0; i < int'(body_len); i++) begin
            result_q.push_back('{status: ST_DATA, ptype: hdr_type,
                                 plen: {1'b0, body_len}, data: body_buf[i],
                                 idx: 6'(i), last: (i == int'(body_len) - 1)});
          end
          restart_hunt();
        end
      end
      default: restart_hunt();
    endcase
  endtask

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst_n) begin
      start_first  = START_FIRST_RST;
      start_second = START_SECOND_RST;
      max_payload  = MAX_PAYLOAD_RST;
      hdr_type     = '0;
      csum_acc     = '0;
      restart_hunt();
      result_q.delete();
      mismatches   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_FIRST:  start_first  = cfg_wdata;
          REG_START_SECOND: start_second = cfg_wdata;
          REG_MAX_PAYLOAD:  max_payload  = cfg_wdata[6:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        got = '{status: status_t'(out_mon.status), ptype: out_mon.packet_type,
                plen: out_mon.payload_length, data: out_mon.data_byte,
                idx: out_mon.byte_index, last: out_mon.last};
        if (result_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: %s", $realtime, result_str(got));
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.ptype !== want.ptype ||
              got.plen !== want.plen || got.data !== want.data ||
              got.idx !== want.idx || got.last !== want.last) begin
            if (mismatches < 10)
              $display("[%0t] result mismatch: expected %s, got %s", $realtime,
                       result_str(want), result_str(got));
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) parse_rx_byte(in_mon.rx_byte);
    end
    pending_results <= result_q.size();
    fail_count      <= mismatches;
  end

endmodule

### tb/tb_sof_length_xor_packet_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sof_length_xor_packet_parser_unit
// Feeds framed byte streams (good packets, bad lengths, bad checks, broken
// starts and noise) through the deframer under several register settings
// and idle/stall mixes; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_sof_length_xor_packet_parser_unit;
  import slxpp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  int unsigned pending_results;
  int unsigned fail_count;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned packet_bytes;
  logic [7:0]  cur_first;
  logic [7:0]  cur_second;
  logic [6:0]  cur_max;
  logic [7:0]  frame_q[$];

  slxpp_in_if  in_ch();
  slxpp_out_if out_ch();

  sof_length_xor_packet_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  slxpp_parse_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending_results(pending_results),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // result-side backpressure
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // hold valid and the byte until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] first, input logic [7:0] second,
                             input logic [6:0] maxp);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= REG_START_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= {1'b0, maxp};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_first  = first;
    cur_second = second;
    cur_max    = maxp;
  endtask

  // queue one frame: mostly well-formed, some noise and broken starts
  task automatic make_packet(input bit full_len);
    int unsigned kind;
    int unsigned lim;
    int unsigned len;
    logic [7:0]  ptype;
    logic [7:0]  csum;
    logic [7:0]  b;
    kind = $urandom_range(99);
    lim  = (cur_max > 7'd64) ? 64 : int'(cur_max);
    if (!full_len && kind < 15) begin
      if (kind < 7) frame_q.push_back(cur_first);
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      return;
    end
    if (!full_len && kind < 22 && cur_first != cur_second) frame_q.push_back(cur_first);
    frame_q.push_back(cur_first);
    frame_q.push_back(cur_second);
    ptype = 8'($urandom);
    frame_q.push_back(ptype);
    kind = $urandom_range(99);
    if (full_len) len = lim;
    else if (kind < 6) len = $urandom_range(lim + 1, 255);
    else if (kind < 10) len = lim;
    else len = $urandom_range(0, (lim < 8) ? lim : 8);
    frame_q.push_back(len[7:0]);
    if (len <= lim) begin
      csum = ptype ^ len[7:0];
      repeat (len) begin
        b = 8'($urandom);
        csum = csum ^ b;
        frame_q.push_back(b);
      end
      if (!full_len && $urandom_range(99) < 12) csum = csum ^ 8'(1 << $urandom_range(7));
      frame_q.push_back(csum);
    end
    packet_bytes += frame_q.size();
  endtask

  task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                           input logic [6:0] maxp, input int unsigned src_pct,
                           input int unsigned snk_pct, input bit with_full);
    load_config(first, second, maxp);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    packet_bytes  = 0;
    if (with_full) begin
      make_packet(1'b1);
      send_frame();
    end
    while (packet_bytes < 70) begin
      make_packet(1'b0);
      send_frame();
    end
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = REG_START_FIRST;
    cfg_wdata     = 8'h00;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    packet_bytes  = 0;
    cur_first     = START_FIRST_RST;
    cur_second    = START_SECOND_RST;
    cur_max       = MAX_PAYLOAD_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: repeated first start with an empty packet, a broken
    // start, an over-long length, a bad check byte, a one-byte packet
    frame_q = '{8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF,
                8'hAA, 8'h12,
                8'hAA, 8'h55, 8'h07, 8'h41,
                8'hAA, 8'h55, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h13,
                8'hAA, 8'h55, 8'h03, 8'h01, 8'h80, 8'h82};
    send_frame();
    drain();

    run_phase(8'hAA, 8'h55, 7'd64, 0, 0, 1'b0);
    run_phase(8'h00, 8'hFF, 7'd0, 49, 0, 1'b0);
    run_phase(8'hFF, 8'h00, 7'd127, 0, 49, 1'b1);
    run_phase(8'h5A, 8'h5A, 7'd5, 12, 12, 1'b0);
    run_phase(8'h3C, 8'hC3, 7'd64, 12, 12, 1'b1);

    snk_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/slxpp_pkg.sv
rtl/slxpp_in_if.sv
rtl/slxpp_out_if.sv
rtl/slxpp_front.sv
rtl/slxpp_cmd_fifo.sv
rtl/slxpp_back.sv
rtl/sof_length_xor_packet_parser_unit.sv
tb/slxpp_parse_checker.sv
tb/tb_sof_length_xor_packet_parser_unit.sv
